FILE: hw/rtl/trs_pkg.sv
// Shared types and constants for the TRS matrix builder.
package trs_pkg;

    // Quaternion fraction bits (Q1.14 by default).
    localparam int QUAT_FRAC_BITS = 14;

    localparam int QUAT_W  = 16;
    localparam int WORD_W  = 32;
    localparam int QPROD_W = 2 * QUAT_W;

    // Rotation entries: |2(ab +/- cd)| reaches 2^32, diagonal carries 2^(2F).
    localparam int ROT_W  = (2 * QUAT_FRAC_BITS + 2 > 34) ? 2 * QUAT_FRAC_BITS + 2 : 34;
    localparam int PROD_W = ROT_W + WORD_W;
    localparam int SH_W   = PROD_W - 2 * QUAT_FRAC_BITS;

    localparam logic signed [ROT_W-1:0] ROT_ONE =
        {{(ROT_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Transactions the block can hold: two front stages, queue, two back stages.
    localparam int PIPE_CAP   = 4 + FIFO_DEPTH;
    localparam int PIPE_CNT_W = $clog2(PIPE_CAP + 1);

    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Input transaction, last field (tx) in the lowest bits.
    typedef struct packed {
        word_t sz;
        word_t sy;
        word_t sx;
        quat_t qw;
        quat_t qz;
        quat_t qy;
        quat_t qx;
        word_t tz;
        word_t ty;
        word_t tx;
    } in_item_t;

    localparam int IN_W = $bits(in_item_t);

    // Output matrix [row][col], row 0 col 0 in the lowest bits.
    typedef word_t [2:0][3:0] out_mat_t;

    localparam int OUT_W = $bits(out_mat_t);

    // Front to back: unscaled rotation entries (row major), scales, translation.
    typedef struct packed {
        rot_t  [8:0] rot;
        word_t [2:0] scale;
        word_t [2:0] trans;
    } rot_item_t;

endpackage

FILE: hw/rtl/trs_front.sv
// Front end: takes input transactions, forms the exact rotation entries.
module trs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  trs_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output trs_pkg::rot_item_t  out_item
);

    typedef logic signed [trs_pkg::QPROD_W-1:0] qprod_t;

    typedef struct packed {
        qprod_t xx;
        qprod_t yy;
        qprod_t zz;
        qprod_t xy;
        qprod_t zw;
        qprod_t zx;
        qprod_t yw;
        qprod_t yz;
        qprod_t xw;
        trs_pkg::word_t [2:0] scale;
        trs_pkg::word_t [2:0] trans;
    } qprod_item_t;

    logic               a_vld_reg;
    qprod_item_t        a_data_reg;
    qprod_item_t        a_data_next;
    logic               a_ready;

    logic               b_vld_reg;
    trs_pkg::rot_item_t b_data_reg;
    trs_pkg::rot_item_t b_data_next;
    logic               b_ready;

    trs_pkg::rot_t      e_xx, e_yy, e_zz, e_xy, e_zw, e_zx, e_yw, e_yz, e_xw;

    assign b_ready  = !b_vld_reg || out_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: the nine quaternion products
    always_comb
    begin
        a_data_next.xx    = in_item.qx * in_item.qx;
        a_data_next.yy    = in_item.qy * in_item.qy;
        a_data_next.zz    = in_item.qz * in_item.qz;
        a_data_next.xy    = in_item.qx * in_item.qy;
        a_data_next.zw    = in_item.qz * in_item.qw;
        a_data_next.zx    = in_item.qz * in_item.qx;
        a_data_next.yw    = in_item.qy * in_item.qw;
        a_data_next.yz    = in_item.qy * in_item.qz;
        a_data_next.xw    = in_item.qx * in_item.qw;
        a_data_next.scale = {in_item.sz, in_item.sy, in_item.sx};
        a_data_next.trans = {in_item.tz, in_item.ty, in_item.tx};
    end

    // Stage B: sums into rotation entries, 2F fraction bits
    always_comb
    begin
        e_xx = trs_pkg::ROT_W'(a_data_reg.xx);
        e_yy = trs_pkg::ROT_W'(a_data_reg.yy);
        e_zz = trs_pkg::ROT_W'(a_data_reg.zz);
        e_xy = trs_pkg::ROT_W'(a_data_reg.xy);
        e_zw = trs_pkg::ROT_W'(a_data_reg.zw);
        e_zx = trs_pkg::ROT_W'(a_data_reg.zx);
        e_yw = trs_pkg::ROT_W'(a_data_reg.yw);
        e_yz = trs_pkg::ROT_W'(a_data_reg.yz);
        e_xw = trs_pkg::ROT_W'(a_data_reg.xw);

        b_data_next.rot[0] = trs_pkg::ROT_ONE - ((e_yy + e_zz) <<< 1);
        b_data_next.rot[1] = (e_xy - e_zw) <<< 1;
        b_data_next.rot[2] = (e_zx + e_yw) <<< 1;
        b_data_next.rot[3] = (e_xy + e_zw) <<< 1;
        b_data_next.rot[4] = trs_pkg::ROT_ONE - ((e_zz + e_xx) <<< 1);
        b_data_next.rot[5] = (e_yz - e_xw) <<< 1;
        b_data_next.rot[6] = (e_zx - e_yw) <<< 1;
        b_data_next.rot[7] = (e_yz + e_xw) <<< 1;
        b_data_next.rot[8] = trs_pkg::ROT_ONE - ((e_xx + e_yy) <<< 1);
        b_data_next.scale  = a_data_reg.scale;
        b_data_next.trans  = a_data_reg.trans;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_vld_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_data_reg <= a_data_next;
        end
        if (b_ready && a_vld_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_item  = b_data_reg;

endmodule

FILE: hw/rtl/trs_fifo.sv
// Short queue decoupling the front end from the scaling back end.
module trs_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  trs_pkg::rot_item_t  wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output trs_pkg::rot_item_t  rd_item
);

    trs_pkg::rot_item_t                 mem_reg [trs_pkg::FIFO_DEPTH];
    logic [trs_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [trs_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [trs_pkg::FIFO_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               do_wr, do_rd;

    assign wr_ready = (cnt_reg != trs_pkg::FIFO_CNT_W'(trs_pkg::FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == trs_pkg::FIFO_PTR_W'(trs_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == trs_pkg::FIFO_PTR_W'(trs_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hw/rtl/trs_back.sv
// Back end: scales rotation entries, floors, saturates and registers the matrix.
module trs_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  trs_pkg::rot_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output trs_pkg::out_mat_t   out_mat
);

    localparam logic signed [trs_pkg::SH_W-1:0] SAT_MAX = trs_pkg::SH_W'(64'sh7FFF_FFFF);
    localparam logic signed [trs_pkg::SH_W-1:0] SAT_MIN = trs_pkg::SH_W'(-64'sh8000_0000);

    function automatic trs_pkg::word_t sat_word(input logic signed [trs_pkg::SH_W-1:0] v);
        trs_pkg::word_t r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[trs_pkg::WORD_W-1:0];
        end
        return r;
    endfunction

    logic                      c_vld_reg;
    trs_pkg::prod_t            c_prod_reg  [9];
    trs_pkg::prod_t            c_prod_next [9];
    trs_pkg::word_t [2:0]      c_trans_reg;
    logic                      c_ready;

    logic                      d_vld_reg;
    trs_pkg::out_mat_t         d_mat_reg;
    trs_pkg::out_mat_t         d_mat_next;
    logic                      d_ready;

    logic signed [trs_pkg::SH_W-1:0] floor_val [9];

    assign d_ready  = !d_vld_reg || out_ready;
    assign c_ready  = !c_vld_reg || d_ready;
    assign in_ready = c_ready;

    // Stage C: entry times column scale, full precision; stage D: floor and clamp
    for (genvar g = 0; g < 9; g++)
    begin : g_entry
        assign c_prod_next[g] = trs_pkg::PROD_W'(in_item.rot[g]) *
                                trs_pkg::PROD_W'(in_item.scale[g % 3]);
        assign floor_val[g]   = trs_pkg::SH_W'(c_prod_reg[g] >>> (2 * trs_pkg::QUAT_FRAC_BITS));
        assign d_mat_next[g / 3][g % 3] = sat_word(floor_val[g]);
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_trans
        assign d_mat_next[r][3] = c_trans_reg[r];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_vld_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_vld_reg <= c_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_prod_reg  <= c_prod_next;
            c_trans_reg <= in_item.trans;
        end
        if (d_ready && c_vld_reg)
        begin
            d_mat_reg <= d_mat_next;
        end
    end

    assign out_valid = d_vld_reg;
    assign out_mat   = d_mat_reg;

endmodule

FILE: hw/rtl/trs_transform_matrix_build_core.sv
// Top level of the TRS affine matrix builder (T*R*S, top three rows).
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-------------------------------
//  s_axis   | in        | tvalid/tready, 1 per cycle   | tx ty tz qx qy qz qw sx sy sz
//  m_axis   | out       | tvalid/tready, 1 per cycle   | 3x4 matrix, Q16.16, row major
//
// Throughput: one transaction per clock on each side while m_axis_tready stays high. An input
// reaches m_axis_tvalid through five register stages (quaternion products, rotation sums,
// queue register, 34x32 scale multipliers, floor/saturate output register), the first of
// them loaded by the accepting edge itself.
// Reset (rst_n, async, active low) empties every stage and the queue; no clearing pass.
// Stalls on m_axis back up through the back end at once; the queue takes the transaction
// already on its way, so with a full stream s_axis_tready drops in the cycle after m_axis_tready falls.
// Fixed point: quaternion Q1.14 (used as given, not normalised), scale and translation
// Q16.16; rotation entries exact, scaled product floored and saturated to 32 bits.
module trs_transform_matrix_build_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tx[31:0] ty[63:32] tz[95:64] qx[111:96] qy[127:112] qz[143:128] qw[159:144]
    // sx[191:160] sy[223:192] sz[255:224]
    input  logic [trs_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // row1_col1..row1_col4, row2_col1..row2_col4, row3_col1..row3_col4, 32 bits each
    output logic [trs_pkg::OUT_W-1:0]  m_axis_tdata
);

    trs_pkg::in_item_t   in_item;
    trs_pkg::rot_item_t  fe_item;
    trs_pkg::rot_item_t  be_item;
    trs_pkg::out_mat_t   out_mat;
    logic                fe_valid, fe_ready;
    logic                be_valid, be_ready;

    assign in_item = trs_pkg::in_item_t'(s_axis_tdata);

    // Front end: products and rotation entries
    trs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_item  (fe_item)
    );

    // Decoupling queue
    trs_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_item  (fe_item),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_item  (be_item)
    );

    // Back end: scaling, floor, saturation, output register
    trs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (be_valid),
        .in_ready  (be_ready),
        .in_item   (be_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_mat   (out_mat)
    );

    assign m_axis_tdata = out_mat;

endmodule

FILE: hw/rtl/trs_checker.sv
// Port-level checks for the TRS matrix builder, bound to the top level.
module trs_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [trs_pkg::OUT_W-1:0]  m_axis_tdata
);

    logic [trs_pkg::PIPE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Transactions accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt_reg != '0)
        else $error("output transaction with nothing outstanding");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= trs_pkg::PIPE_CNT_W'(trs_pkg::PIPE_CAP))
        else $error("more transactions in flight than the pipeline holds");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == trs_pkg::PIPE_CNT_W'(trs_pkg::PIPE_CAP) && !m_axis_tready
        |-> !s_axis_tready)
        else $error("input accepted while full and output stalled");

endmodule

bind trs_transform_matrix_build_core trs_checker u_trs_checker (.*);
